>>> hdl/abec_pkg.sv
// ----------------------------------------------------------------------------
// abec_pkg: shared types and constants for the line calculator
// operation codes, status codes, character codes and the control structs
// passed between the lexer/sequencer and the arithmetic unit
// ----------------------------------------------------------------------------
package abec_pkg;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_OK       = 2'd0;
	localparam status_t STATUS_SYNTAX   = 2'd1;
	localparam status_t STATUS_DIV_ZERO = 2'd2;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic div_zero;
	} alu_rsp_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_oper(input logic [7:0] c);
		return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
	endfunction

	function automatic op_t oper_of(input logic [7:0] c);
		op_t o;
		case (c)
			CH_PLUS:  o = OP_ADD;
			CH_MINUS: o = OP_SUB;
			CH_STAR:  o = OP_MUL;
			default:  o = OP_DIV;
		endcase
		return o;
	endfunction

endpackage

>>> hdl/abec_alu.sv
// ----------------------------------------------------------------------------
// abec_alu: iterative arithmetic unit
// add and subtract in one pass, multiply by shift and add, signed divide by
// restoring division on magnitudes, one bit per cycle
// ----------------------------------------------------------------------------
module abec_alu #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  abec_pkg::alu_req_t        req,
	input  logic [VALUE_WIDTH-1:0]    a,
	input  logic [VALUE_WIDTH-1:0]    b,
	output abec_pkg::alu_rsp_t        rsp,
	output logic [VALUE_WIDTH-1:0]    result
);

	localparam int CW = $clog2(VALUE_WIDTH);
	localparam logic [CW-1:0] LAST_BIT = CW'(VALUE_WIDTH - 1);

	typedef enum logic [4:0] {
		A_IDLE = 5'b00001,
		A_MUL  = 5'b00010,
		A_DIV  = 5'b00100,
		A_FIX  = 5'b01000,
		A_DONE = 5'b10000
	} alu_state_t;

	alu_state_t             state_q;
	logic [CW-1:0]          cnt_q;
	logic                   neg_q;
	logic                   dz_q;
	abec_pkg::op_t          op_q;
	logic [VALUE_WIDTH-1:0] x_q;
	logic [VALUE_WIDTH-1:0] y_q;
	logic [VALUE_WIDTH-1:0] acc_q;
	logic [VALUE_WIDTH-1:0] res_q;

	logic [VALUE_WIDTH-1:0] mag_a;
	logic [VALUE_WIDTH-1:0] mag_b;
	logic [VALUE_WIDTH:0]   trial;
	logic [VALUE_WIDTH-1:0] fix_src;

	assign mag_a = a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
	assign mag_b = b[VALUE_WIDTH-1] ? (~b + 1'b1) : b;

	// partial remainder with the next dividend bit, less the divisor
	assign trial   = {acc_q, x_q[VALUE_WIDTH-1]} - {1'b0, y_q};
	assign fix_src = (op_q == abec_pkg::OP_MUL) ? acc_q : x_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
			dz_q    <= 1'b0;
			op_q    <= abec_pkg::OP_ADD;
		end else begin
			case (state_q)
				A_IDLE: begin
					if (req.start) begin
						op_q  <= req.op;
						cnt_q <= '0;
						dz_q  <= 1'b0;
						neg_q <= 1'b0;
						case (req.op)
							abec_pkg::OP_ADD: begin
								state_q <= A_DONE;
							end
							abec_pkg::OP_SUB: begin
								state_q <= A_DONE;
							end
							abec_pkg::OP_MUL: begin
								state_q <= A_MUL;
							end
							default: begin
								if (b == '0) begin
									dz_q    <= 1'b1;
									state_q <= A_DONE;
								end else begin
									neg_q   <= a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
									state_q <= A_DIV;
								end
							end
						endcase
					end
				end
				A_MUL, A_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_BIT) begin
						state_q <= A_FIX;
					end
				end
				A_FIX: begin
					state_q <= A_DONE;
				end
				A_DONE: begin
					state_q <= A_IDLE;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				acc_q <= '0;
				case (req.op)
					abec_pkg::OP_ADD: begin
						res_q <= a + b;
						x_q   <= a;
						y_q   <= b;
					end
					abec_pkg::OP_SUB: begin
						res_q <= a - b;
						x_q   <= a;
						y_q   <= b;
					end
					abec_pkg::OP_MUL: begin
						res_q <= '0;
						x_q   <= a;
						y_q   <= b;
					end
					default: begin
						res_q <= '0;
						x_q   <= mag_a;
						y_q   <= mag_b;
					end
				endcase
			end
			A_MUL: begin
				if (y_q[0]) begin
					acc_q <= acc_q + x_q;
				end
				x_q <= {x_q[VALUE_WIDTH-2:0], 1'b0};
				y_q <= {1'b0, y_q[VALUE_WIDTH-1:1]};
			end
			A_DIV: begin
				if (!trial[VALUE_WIDTH]) begin
					acc_q <= trial[VALUE_WIDTH-1:0];
					x_q   <= {x_q[VALUE_WIDTH-2:0], 1'b1};
				end else begin
					acc_q <= {acc_q[VALUE_WIDTH-2:0], x_q[VALUE_WIDTH-1]};
					x_q   <= {x_q[VALUE_WIDTH-2:0], 1'b0};
				end
			end
			A_FIX: begin
				res_q <= neg_q ? (~fix_src + 1'b1) : fix_src;
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign rsp.done     = (state_q == A_DONE);
	assign rsp.div_zero = dz_q;
	assign result       = res_q;

endmodule

>>> hdl/ascii_binary_expression_calculator.sv
// ----------------------------------------------------------------------------
// ascii_binary_expression_calculator: one-line integer calculator
// end of line holds the input until the line's result and status reach the
// output register; * and / run one bit per cycle in the shared unit, and a full
// output register keeps the new result back until its beat leaves; reset clears
// to the start of a line
// ----------------------------------------------------------------------------
module ascii_binary_expression_calculator #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // ch
	input  logic        s_axis_tlast,   // end_of_line
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // value
	output logic [1:0]  m_axis_tuser    // status
);

	typedef enum logic [7:0] {
		PH_LEFT0  = 8'b0000_0001,
		PH_LEFT   = 8'b0000_0010,
		PH_OP     = 8'b0000_0100,
		PH_RIGHT0 = 8'b0000_1000,
		PH_RIGHT  = 8'b0001_0000,
		PH_TRAIL  = 8'b0010_0000,
		PH_DONE   = 8'b0100_0000,
		PH_ERROR  = 8'b1000_0000
	} phase_t;

	typedef enum logic [2:0] {
		C_IDLE = 3'b001,
		C_CALC = 3'b010,
		C_HOLD = 3'b100
	} ctrl_t;

	phase_t                 phase_q;
	ctrl_t                  ctrl_q;
	abec_pkg::op_t          op_q;
	logic [VALUE_WIDTH-1:0] left_q;
	logic [VALUE_WIDTH-1:0] right_q;
	logic [VALUE_WIDTH-1:0] pend_val_q;
	abec_pkg::status_t      pend_stat_q;
	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_val_q;
	abec_pkg::status_t      out_stat_q;

	logic                   in_beat;
	logic                   char_beat;
	logic                   eol_beat;
	logic                   line_ok;
	logic [7:0]             c;
	logic [VALUE_WIDTH-1:0] digit;
	logic [VALUE_WIDTH-1:0] acc_src;
	logic [VALUE_WIDTH-1:0] acc_next;
	logic                   out_free;
	abec_pkg::alu_req_t     alu_req;
	abec_pkg::alu_rsp_t     alu_rsp;
	logic [VALUE_WIDTH-1:0] alu_result;

	assign s_axis_tready = (ctrl_q == C_IDLE);
	assign in_beat   = s_axis_tvalid && s_axis_tready;
	assign char_beat = in_beat && !s_axis_tlast;
	assign eol_beat  = in_beat && s_axis_tlast;
	assign c         = s_axis_tdata;
	assign line_ok   = (phase_q == PH_RIGHT) || (phase_q == PH_TRAIL) || (phase_q == PH_DONE);
	assign out_free  = !out_valid_q || m_axis_tready;

	// acc * 10 + digit, wrapping at the value width
	assign digit    = VALUE_WIDTH'(c - abec_pkg::CH_ZERO);
	assign acc_src  = (phase_q == PH_LEFT) ? left_q : right_q;
	assign acc_next = {acc_src[VALUE_WIDTH-4:0], 3'b000} + {acc_src[VALUE_WIDTH-2:0], 1'b0}
		+ digit;

	assign alu_req.start = eol_beat && line_ok;
	assign alu_req.op    = op_q;

	abec_alu #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (left_q),
		.b      (right_q),
		.rsp    (alu_rsp),
		.result (alu_result)
	);

	// lexer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEFT0;
			op_q    <= abec_pkg::OP_ADD;
			left_q  <= '0;
			right_q <= '0;
		end else if (eol_beat) begin
			phase_q <= PH_LEFT0;
		end else if (char_beat) begin
			case (phase_q)
				PH_LEFT0: begin
					if (abec_pkg::is_digit(c)) begin
						left_q  <= digit;
						phase_q <= PH_LEFT;
					end else if (!abec_pkg::is_space(c)) begin
						phase_q <= PH_ERROR;
					end
				end
				PH_LEFT: begin
					if (abec_pkg::is_digit(c)) begin
						left_q <= acc_next;
					end else if (abec_pkg::is_space(c)) begin
						phase_q <= PH_OP;
					end else if (abec_pkg::is_oper(c)) begin
						op_q    <= abec_pkg::oper_of(c);
						phase_q <= PH_RIGHT0;
					end else begin
						phase_q <= PH_ERROR;
					end
				end
				PH_OP: begin
					if (abec_pkg::is_oper(c)) begin
						op_q    <= abec_pkg::oper_of(c);
						phase_q <= PH_RIGHT0;
					end else if (!abec_pkg::is_space(c)) begin
						phase_q <= PH_ERROR;
					end
				end
				PH_RIGHT0: begin
					if (abec_pkg::is_digit(c)) begin
						right_q <= digit;
						phase_q <= PH_RIGHT;
					end else if (!abec_pkg::is_space(c)) begin
						phase_q <= PH_ERROR;
					end
				end
				PH_RIGHT: begin
					if (abec_pkg::is_digit(c)) begin
						right_q <= acc_next;
					end else if (abec_pkg::is_space(c)) begin
						phase_q <= PH_TRAIL;
					end else if (abec_pkg::is_oper(c) || (c == abec_pkg::CH_NUL)) begin
						phase_q <= PH_DONE;
					end else begin
						phase_q <= PH_ERROR;
					end
				end
				PH_TRAIL: begin
					if (abec_pkg::is_digit(c) || abec_pkg::is_oper(c)
						|| (c == abec_pkg::CH_NUL)) begin
						phase_q <= PH_DONE;
					end else if (!abec_pkg::is_space(c)) begin
						phase_q <= PH_ERROR;
					end
				end
				default: begin
					phase_q <= phase_q;
				end
			endcase
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= C_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a pending result refills the output register as the old beat leaves
			if ((ctrl_q == C_HOLD) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (ctrl_q)
				C_IDLE: begin
					if (eol_beat) begin
						ctrl_q <= line_ok ? C_CALC : C_HOLD;
					end
				end
				C_CALC: begin
					if (alu_rsp.done) begin
						ctrl_q <= C_HOLD;
					end
				end
				C_HOLD: begin
					if (out_free) begin
						ctrl_q <= C_IDLE;
					end
				end
				default: begin
					ctrl_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (eol_beat && !line_ok) begin
			pend_val_q  <= '0;
			pend_stat_q <= abec_pkg::STATUS_SYNTAX;
		end else if ((ctrl_q == C_CALC) && alu_rsp.done) begin
			pend_val_q  <= alu_rsp.div_zero ? '0 : alu_result;
			pend_stat_q <= alu_rsp.div_zero ? abec_pkg::STATUS_DIV_ZERO : abec_pkg::STATUS_OK;
		end
		if ((ctrl_q == C_HOLD) && out_free) begin
			out_val_q  <= pend_val_q;
			out_stat_q <= pend_stat_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_stat_q;

	generate
		if (VALUE_WIDTH >= 32) begin : g_trunc
			assign m_axis_tdata = out_val_q[31:0];
		end else begin : g_ext
			assign m_axis_tdata = {{(32 - VALUE_WIDTH){1'b0}}, out_val_q};
		end
	endgenerate

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the one-line integer calculator
// feeds text lines and end-of-line beats through the input stream, predicts
// each line's value and status in the bench and checks every output beat
// against the oldest prediction; both streams idle and stall at random
// ----------------------------------------------------------------------------
module tb_top;

	localparam int IDLE_LIMIT = 5000;
	localparam int TAIL_CYCLES = 64;
	localparam int LONG_HOLD = 400;

	typedef enum logic [2:0] {
		AT_LHS_START,
		IN_LHS,
		AT_OPER,
		AT_RHS_START,
		IN_RHS,
		AT_TAIL,
		LINE_DONE,
		LINE_BAD
	} calc_phase_t;

	typedef enum {CK_SPACE, CK_DIGIT, CK_OPER, CK_NUL, CK_OTHER} char_kind_t;

	typedef struct {
		logic [31:0]       value;
		abec_pkg::status_t status;
	} calc_result_t;

	typedef struct {
		logic [7:0] ch;
		logic       eol;
		bit         wait_idle;
	} line_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;

	line_beat_t   chars_to_send[$];
	calc_result_t results_due[$];

	calc_phase_t   calc_phase = AT_LHS_START;
	logic [31:0]   calc_lhs = '0;
	logic [31:0]   calc_rhs = '0;
	abec_pkg::op_t calc_op = abec_pkg::OP_ADD;

	int n_queued = 0;
	int n_fail = 0;
	int n_results = 0;
	int send_gap = 0;
	int send_calm = 0;
	int recv_gap = 0;
	int recv_calm = 0;
	int hold_left = 0;
	int idle_cycles = 0;
	bit offer;
	bit take;
	line_beat_t   next_beat;
	calc_result_t want;

	ascii_binary_expression_calculator #(
		.VALUE_WIDTH(32)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic char_kind_t classify(input logic [7:0] c, output abec_pkg::op_t o);
		o = abec_pkg::OP_ADD;
		case (c)
			abec_pkg::CH_NUL:   return CK_NUL;
			abec_pkg::CH_PLUS:  return CK_OPER;
			abec_pkg::CH_MINUS: begin
				o = abec_pkg::OP_SUB;
				return CK_OPER;
			end
			abec_pkg::CH_STAR:  begin
				o = abec_pkg::OP_MUL;
				return CK_OPER;
			end
			abec_pkg::CH_SLASH: begin
				o = abec_pkg::OP_DIV;
				return CK_OPER;
			end
			default: ;
		endcase
		if (c == abec_pkg::CH_SPACE || (c >= abec_pkg::CH_TAB && c <= abec_pkg::CH_CR))
			return CK_SPACE;
		if (c >= abec_pkg::CH_ZERO && c <= abec_pkg::CH_NINE)
			return CK_DIGIT;
		return CK_OTHER;
	endfunction

	// signed quotient through magnitudes, so the most negative value over -1 wraps
	function automatic logic [31:0] trunc_quotient(input logic [31:0] a, input logic [31:0] b);
		logic [31:0] ma;
		logic [31:0] mb;
		logic [31:0] q;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		return (a[31] ^ b[31]) ? -q : q;
	endfunction

	task automatic calc_take(input logic [7:0] c, input logic eol);
		char_kind_t    k;
		abec_pkg::op_t o;
		calc_result_t  r;
		if (!eol) begin
			k = classify(c, o);
			case (calc_phase)
				AT_LHS_START: begin
					if (k == CK_DIGIT) begin
						calc_lhs = 32'(c - abec_pkg::CH_ZERO);
						calc_phase = IN_LHS;
					end else if (k != CK_SPACE) begin
						calc_phase = LINE_BAD;
					end
				end
				IN_LHS: begin
					if (k == CK_DIGIT) begin
						calc_lhs = calc_lhs * 10 + 32'(c - abec_pkg::CH_ZERO);
					end else if (k == CK_SPACE) begin
						calc_phase = AT_OPER;
					end else if (k == CK_OPER) begin
						calc_op = o;
						calc_phase = AT_RHS_START;
					end else begin
						calc_phase = LINE_BAD;
					end
				end
				AT_OPER: begin
					if (k == CK_OPER) begin
						calc_op = o;
						calc_phase = AT_RHS_START;
					end else if (k != CK_SPACE) begin
						calc_phase = LINE_BAD;
					end
				end
				AT_RHS_START: begin
					if (k == CK_DIGIT) begin
						calc_rhs = 32'(c - abec_pkg::CH_ZERO);
						calc_phase = IN_RHS;
					end else if (k != CK_SPACE) begin
						calc_phase = LINE_BAD;
					end
				end
				IN_RHS: begin
					if (k == CK_DIGIT)
						calc_rhs = calc_rhs * 10 + 32'(c - abec_pkg::CH_ZERO);
					else if (k == CK_SPACE)
						calc_phase = AT_TAIL;
					else if (k == CK_OPER || k == CK_NUL)
						calc_phase = LINE_DONE;
					else
						calc_phase = LINE_BAD;
				end
				AT_TAIL: begin
					if (k == CK_DIGIT || k == CK_OPER || k == CK_NUL)
						calc_phase = LINE_DONE;
					else if (k != CK_SPACE)
						calc_phase = LINE_BAD;
				end
				default: ;
			endcase
		end else begin
			r.value = '0;
			r.status = abec_pkg::STATUS_OK;
			if (calc_phase inside {IN_RHS, AT_TAIL, LINE_DONE}) begin
				case (calc_op)
					abec_pkg::OP_ADD: r.value = calc_lhs + calc_rhs;
					abec_pkg::OP_SUB: r.value = calc_lhs - calc_rhs;
					abec_pkg::OP_MUL: r.value = calc_lhs * calc_rhs;
					default: begin
						if (calc_rhs == '0)
							r.status = abec_pkg::STATUS_DIV_ZERO;
						else
							r.value = trunc_quotient(calc_lhs, calc_rhs);
					end
				endcase
			end else begin
				r.status = abec_pkg::STATUS_SYNTAX;
			end
			results_due.push_back(r);
			calc_phase = AT_LHS_START;
			calc_lhs = '0;
			calc_rhs = '0;
			calc_op = abec_pkg::OP_ADD;
		end
	endtask

	// mostly short gaps, a few long ones, and now and then a calm stretch with none
	function automatic int next_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm = $urandom_range(30, 80);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// stimulus building

	task automatic send_char(input logic [7:0] c);
		chars_to_send.push_back('{ch: c, eol: 1'b0, wait_idle: 1'b0});
		n_queued++;
	endtask

	task automatic send_eol();
		// the character lane carries noise on end-of-line beats
		chars_to_send.push_back('{ch: 8'($urandom_range(0, 255)), eol: 1'b1, wait_idle: 1'b0});
		n_queued++;
	endtask

	task automatic pause_until_idle();
		chars_to_send.push_back('{ch: abec_pkg::CH_NUL, eol: 1'b0, wait_idle: 1'b1});
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	function automatic logic [7:0] space_char();
		int r;
		r = $urandom_range(0, 7);
		return (r >= 5) ? abec_pkg::CH_SPACE : 8'(abec_pkg::CH_TAB + r);
	endfunction

	function automatic logic [7:0] oper_char();
		case ($urandom_range(0, 3))
			0: return abec_pkg::CH_PLUS;
			1: return abec_pkg::CH_MINUS;
			2: return abec_pkg::CH_STAR;
			default: return abec_pkg::CH_SLASH;
		endcase
	endfunction

	function automatic logic [7:0] token_char();
		case ($urandom_range(0, 6))
			0, 1, 2: return 8'(abec_pkg::CH_ZERO + $urandom_range(0, 9));
			3, 4: return oper_char();
			5: return space_char();
			default: return abec_pkg::CH_NUL;
		endcase
	endfunction

	function automatic logic [7:0] illegal_char();
		logic [7:0]    c;
		abec_pkg::op_t o;
		do
			c = 8'($urandom_range(0, 255));
		while (classify(c, o) != CK_OTHER);
		return c;
	endfunction

	function automatic string number_text();
		int    r;
		int    n;
		string s;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			s = $sformatf("%0d", $urandom_range(0, 99));
		end else if (r < 70) begin
			s = $sformatf("%0d", $urandom());
		end else if (r < 85) begin
			case ($urandom_range(0, 4))
				0: s = "0";
				1: s = "1";
				2: s = "2147483647";
				3: s = "2147483648";
				default: s = "4294967295";
			endcase
		end else begin
			// long enough to wrap the accumulator
			s = "";
			n = $urandom_range(11, 16);
			repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
		end
		if ($urandom_range(0, 9) == 0)
			s = {"00", s};
		return s;
	endfunction

	task automatic send_spaces();
		if ($urandom_range(0, 99) >= 60)
			repeat ($urandom_range(1, 3)) send_char(space_char());
	endtask

	task automatic send_junk();
		repeat ($urandom_range(0, 4)) send_char(8'($urandom_range(0, 255)));
	endtask

	task automatic make_line();
		int         kind;
		logic [7:0] oc;
		string      lhs_txt;
		string      rhs_txt;
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			repeat ($urandom_range(0, 8)) send_char(8'($urandom_range(0, 255)));
		end else if (kind < 18) begin
			repeat ($urandom_range(1, 8)) send_char(token_char());
		end else begin
			oc = oper_char();
			lhs_txt = number_text();
			rhs_txt = number_text();
			if (oc == abec_pkg::CH_SLASH) begin
				case ($urandom_range(0, 9))
					0: rhs_txt = "0";
					1: rhs_txt = "000";
					2: begin
						lhs_txt = "2147483648";
						rhs_txt = "4294967295";
					end
					default: ;
				endcase
			end
			// a few lines lose one of their three tokens
			send_spaces();
			if (kind >= 22)
				send_text(lhs_txt);
			send_spaces();
			if (kind < 22 || kind >= 26)
				send_char(oc);
			send_spaces();
			if (kind < 26 || kind >= 30)
				send_text(rhs_txt);
			case ($urandom_range(0, 9))
				0, 1, 2, 3: ;
				4: send_spaces();
				5, 6: begin
					send_char(space_char());
					send_char(token_char());
					send_junk();
				end
				7: begin
					send_char(illegal_char());
					send_junk();
				end
				8: begin
					send_char(abec_pkg::CH_NUL);
					send_junk();
				end
				default: begin
					send_char(oper_char());
					send_junk();
				end
			endcase
		end
		send_eol();
	endtask

	// input stream driver
	always @(posedge clk) begin
		if (arst_n) begin
			offer = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				calc_take(s_axis_tdata, s_axis_tlast);
				offer = 1'b0;
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (chars_to_send.size() != 0) begin
					if (chars_to_send[0].wait_idle) begin
						if (results_due.size() == 0)
							void'(chars_to_send.pop_front());
					end else begin
						next_beat = chars_to_send.pop_front();
						s_axis_tdata <= next_beat.ch;
						s_axis_tlast <= next_beat.eol;
						offer = 1'b1;
						send_gap = next_gap(send_calm);
					end
				end
			end
			s_axis_tvalid <= offer;
		end
	end

	// output stream monitor and ready generator
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				n_results++;
				if (results_due.size() == 0) begin
					$error("result beat with nothing expected: value %0d status %0d",
						$signed(m_axis_tdata), m_axis_tuser);
					n_fail++;
				end else begin
					want = results_due.pop_front();
					if (m_axis_tdata !== want.value) begin
						$error("value: expected %0d, got %0d", $signed(want.value),
							$signed(m_axis_tdata));
						n_fail++;
					end
					if (m_axis_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
						n_fail++;
					end
				end
				// long back-pressure so the block fills up and stalls its input
				if (n_results == 10 || n_results == 60)
					hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				take = 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				take = 1'b0;
			end else begin
				take = 1'b1;
				recv_gap = next_gap(recv_calm);
			end
			m_axis_tready <= take;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** ascii_binary_expression_calculator: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;

		// empty line, each operation, divide by zero
		send_eol();
		send_text("7+5");
		send_eol();
		send_text("3-9");
		send_eol();
		send_text("6*7");
		send_eol();
		send_text("8/0");
		send_eol();
		// trailing digit accepted, the rest ignored
		send_text("7/2 5x");
		send_eol();
		// top character code where a token is still examined
		send_text("1+1");
		send_char(8'hFF);
		send_eol();
		// nul before any operand
		send_char(abec_pkg::CH_NUL);
		send_eol();
		pause_until_idle();

		while (n_queued < 730)
			make_line();
		pause_until_idle();
		while (n_queued < 1430)
			make_line();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (chars_to_send.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (n_fail == 0)
			$display("** ascii_binary_expression_calculator: PASSED **");
		else
			$display("** ascii_binary_expression_calculator: FAILED **");
		$finish;
	end

endmodule
